### sv/spt_pkg.sv
// Shared types and constants for the stereo point triangulation block
package spt_pkg;

    localparam int COORD_W_DEF   = 16;
    localparam int FRAC_BITS_DEF = 4;
    localparam int BASE_W        = 12;
    localparam int OUT_W         = 32;
    localparam int LANES         = 3;
    localparam int CFG_IDX_W     = 2;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    localparam int RST_PRINCIPAL_X = 5120;
    localparam int RST_PRINCIPAL_Y = 3840;
    localparam int RST_FOCAL       = 8000;
    localparam int RST_BASELINE    = 60;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRINCIPAL_X,
        REG_PRINCIPAL_Y,
        REG_FOCAL,
        REG_BASELINE
    } t_reg_idx;

    typedef struct packed {
        logic             vld;
        logic             zero;
        logic [LANES-1:0] neg;
    } t_ctrl;

endpackage

### sv/spt_front.sv
// Configuration registers, disparity and numerator products
module spt_front #(
    parameter int COORD_WIDTH = spt_pkg::COORD_W_DEF,
    parameter int FRAC_BITS   = spt_pkg::FRAC_BITS_DEF,
    parameter int NUMW        = COORD_WIDTH + spt_pkg::BASE_W + FRAC_BITS
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  logic [COORD_WIDTH-1:0]                     i_left_x,
    input  logic [COORD_WIDTH-1:0]                     i_left_y,
    input  logic [COORD_WIDTH-1:0]                     i_right_x,
    input  logic                                       i_cfg_we,
    input  logic [spt_pkg::CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [COORD_WIDTH-1:0]                     i_cfg_data,
    output spt_pkg::t_ctrl                             o_ctrl,
    output logic [COORD_WIDTH-1:0]                     o_den,
    output logic [spt_pkg::LANES-1:0][NUMW-1:0]        o_num
);

    localparam int PW = COORD_WIDTH + spt_pkg::BASE_W;

    logic [COORD_WIDTH-1:0]                r_px, r_py, r_focal;
    logic [spt_pkg::BASE_W-1:0]            r_base;
    spt_pkg::t_ctrl                        r_ctrl, n_ctrl;
    logic [COORD_WIDTH-1:0]                r_den, n_den;
    logic [spt_pkg::LANES-1:0][NUMW-1:0]   r_num, n_num;

    logic signed [COORD_WIDTH:0] d, dx, dy;
    logic [COORD_WIDTH-1:0]      mx, my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px    <= COORD_WIDTH'(spt_pkg::RST_PRINCIPAL_X);
            r_py    <= COORD_WIDTH'(spt_pkg::RST_PRINCIPAL_Y);
            r_focal <= COORD_WIDTH'(spt_pkg::RST_FOCAL);
            r_base  <= spt_pkg::BASE_W'(spt_pkg::RST_BASELINE);
        end else if (i_cfg_we) begin
            case (spt_pkg::t_reg_idx'(i_cfg_index))
                spt_pkg::REG_PRINCIPAL_X: r_px    <= i_cfg_data;
                spt_pkg::REG_PRINCIPAL_Y: r_py    <= i_cfg_data;
                spt_pkg::REG_FOCAL:       r_focal <= i_cfg_data;
                spt_pkg::REG_BASELINE:    r_base  <= i_cfg_data[spt_pkg::BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        d  = $signed({1'b0, i_left_x}) - $signed({1'b0, i_right_x});
        dx = $signed({1'b0, i_left_x}) - $signed({1'b0, r_px});
        dy = $signed({1'b0, r_py}) - $signed({1'b0, i_left_y});
        n_den = d[COORD_WIDTH] ? COORD_WIDTH'(-d) : d[COORD_WIDTH-1:0];
        mx    = dx[COORD_WIDTH] ? COORD_WIDTH'(-dx) : dx[COORD_WIDTH-1:0];
        my    = dy[COORD_WIDTH] ? COORD_WIDTH'(-dy) : dy[COORD_WIDTH-1:0];
        n_ctrl.vld  = i_valid;
        n_ctrl.zero = (d == '0);
        n_ctrl.neg[spt_pkg::LANE_X] = dx[COORD_WIDTH] ^ d[COORD_WIDTH];
        n_ctrl.neg[spt_pkg::LANE_Y] = dy[COORD_WIDTH] ^ d[COORD_WIDTH];
        n_ctrl.neg[spt_pkg::LANE_Z] = d[COORD_WIDTH];
        n_num[spt_pkg::LANE_X] = NUMW'(PW'(mx) * PW'(r_base)) << FRAC_BITS;
        n_num[spt_pkg::LANE_Y] = NUMW'(PW'(my) * PW'(r_base)) << FRAC_BITS;
        n_num[spt_pkg::LANE_Z] = NUMW'(PW'(r_focal) * PW'(r_base)) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= n_den;
            r_num <= n_num;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_den  = r_den;
    assign o_num  = r_num;

endmodule

### sv/spt_cell.sv
// One restoring division cell: one quotient bit for each of the three lanes
module spt_cell #(
    parameter int COORD_WIDTH = spt_pkg::COORD_W_DEF,
    parameter int NUMW        = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  spt_pkg::t_ctrl                             i_ctrl,
    input  logic [COORD_WIDTH-1:0]                     i_den,
    input  logic [spt_pkg::LANES-1:0][NUMW-1:0]        i_num,
    input  logic [spt_pkg::LANES-1:0][COORD_WIDTH-1:0] i_rem,
    input  logic [spt_pkg::LANES-1:0][NUMW-1:0]        i_quo,
    output spt_pkg::t_ctrl                             o_ctrl,
    output logic [COORD_WIDTH-1:0]                     o_den,
    output logic [spt_pkg::LANES-1:0][NUMW-1:0]        o_num,
    output logic [spt_pkg::LANES-1:0][COORD_WIDTH-1:0] o_rem,
    output logic [spt_pkg::LANES-1:0][NUMW-1:0]        o_quo
);

    spt_pkg::t_ctrl                               r_ctrl;
    logic [COORD_WIDTH-1:0]                       r_den;
    logic [spt_pkg::LANES-1:0][NUMW-1:0]          r_num, n_num;
    logic [spt_pkg::LANES-1:0][COORD_WIDTH-1:0]   r_rem, n_rem;
    logic [spt_pkg::LANES-1:0][NUMW-1:0]          r_quo, n_quo;
    logic [spt_pkg::LANES-1:0][COORD_WIDTH:0]     tmp, dif;
    logic [spt_pkg::LANES-1:0]                    ge;

    always_comb begin
        for (int k = 0; k < spt_pkg::LANES; k++) begin
            tmp[k]   = {i_rem[k], i_num[k][NUMW-1]};
            ge[k]    = tmp[k] >= {1'b0, i_den};
            dif[k]   = tmp[k] - {1'b0, i_den};
            n_rem[k] = ge[k] ? dif[k][COORD_WIDTH-1:0] : tmp[k][COORD_WIDTH-1:0];
            n_num[k] = i_num[k] << 1;
            n_quo[k] = {i_quo[k][NUMW-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= i_den;
            r_num <= n_num;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_den  = r_den;
    assign o_num  = r_num;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;

endmodule

### sv/spt_back.sv
// Sign, saturation, output register and skid word
module spt_back #(
    parameter int NUMW = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spt_pkg::t_ctrl                      i_ctrl,
    input  logic [spt_pkg::LANES-1:0][NUMW-1:0] i_quo,
    input  logic                                i_stall,
    output logic                                o_en,
    output logic                                o_valid,
    output logic [spt_pkg::OUT_W-1:0]           o_pos_x,
    output logic [spt_pkg::OUT_W-1:0]           o_pos_y,
    output logic [spt_pkg::OUT_W-1:0]           o_pos_z,
    output logic                                o_zero_disparity,
    output logic                                o_saturated
);

    localparam int OW = spt_pkg::OUT_W;
    localparam int MW = ((NUMW > OW) ? NUMW : OW) + 1;
    localparam logic [MW-1:0] LIM_NEG = MW'({1'b1, {(OW-1){1'b0}}});
    localparam logic [MW-1:0] LIM_POS = LIM_NEG - MW'(1);
    localparam int WW = spt_pkg::LANES * OW + 2;

    logic [spt_pkg::LANES-1:0][OW-1:0] val;
    logic [spt_pkg::LANES-1:0]         clip;
    logic [MW-1:0]                     ext;
    logic [WW-1:0]                     word;
    logic                              r_out_vld, r_skid_full;
    logic [WW-1:0]                     r_out, r_skid;
    logic                              take;

    always_comb begin
        for (int k = 0; k < spt_pkg::LANES; k++) begin
            ext = MW'(i_quo[k]);
            clip[k] = 1'b0;
            if (i_ctrl.zero) begin
                val[k] = '0;
            end else if (i_ctrl.neg[k]) begin
                if (ext > LIM_NEG) begin
                    val[k]  = LIM_NEG[OW-1:0];
                    clip[k] = 1'b1;
                end else begin
                    val[k] = OW'(-ext);
                end
            end else if (ext > LIM_POS) begin
                val[k]  = LIM_POS[OW-1:0];
                clip[k] = 1'b1;
            end else begin
                val[k] = ext[OW-1:0];
            end
        end
        word = {val[spt_pkg::LANE_X], val[spt_pkg::LANE_Y], val[spt_pkg::LANE_Z],
                i_ctrl.zero, |clip};
    end

    assign take = r_out_vld && !i_stall;
    assign o_en = !r_skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (take) begin
                r_skid_full <= 1'b0;
            end
        end else if (!r_out_vld || take) begin
            r_out_vld <= i_ctrl.vld;
        end else if (i_ctrl.vld) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || take) begin
            r_out <= word;
        end else begin
            r_skid <= word;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_pos_x          = r_out[WW-1 -: OW];
    assign o_pos_y          = r_out[WW-1-OW -: OW];
    assign o_pos_z          = r_out[WW-1-2*OW -: OW];
    assign o_zero_disparity = r_out[1];
    assign o_saturated      = r_out[0];

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |-> r_out_vld) else $error("skid word held without output word");

    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_disparity) |-> (o_pos_x == '0 && o_pos_y == '0 &&
        o_pos_z == '0 && !o_saturated)) else $error("zero disparity word not clear");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_pos_x == LIM_NEG[OW-1:0] ||
        o_pos_x == LIM_POS[OW-1:0] || o_pos_y == LIM_NEG[OW-1:0] ||
        o_pos_y == LIM_POS[OW-1:0] || o_pos_z == LIM_NEG[OW-1:0] ||
        o_pos_z == LIM_POS[OW-1:0])) else $error("saturated word has no limit value");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_full && !i_stall) |=> !r_skid_full) else $error("skid word not drained");

endmodule

### sv/stereo_point_triangulation.sv
// Stereo point triangulation top level: front stage, divider cell chain, output stage
//
// Input channel: i_valid/o_stall carry one matched point (left x, left y,
// right x); a word is taken when i_valid is high and o_stall is low.
// Output channel: o_valid/i_stall carry the 3-D position, the zero
// disparity flag and the saturation flag, one word per input word, in order.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (principal x, principal y, focal length, baseline); write only when idle.
// One product stage, one restoring division cell per quotient bit, one output
// stage. Throughput: one word per cycle while the receiver does not stall.
// When the receiver stalls, one further word is held in a skid register;
// o_stall then rises and the whole chain holds until the output drains.
// Reset is synchronous: it empties the chain and loads the register defaults.
module stereo_point_triangulation #(
    parameter int COORD_WIDTH = spt_pkg::COORD_W_DEF,
    parameter int FRAC_BITS   = spt_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [COORD_WIDTH-1:0]         i_left_x,
    input  logic [COORD_WIDTH-1:0]         i_left_y,
    input  logic [COORD_WIDTH-1:0]         i_right_x,
    input  logic                           i_cfg_we,
    input  logic [spt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COORD_WIDTH-1:0]         i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [spt_pkg::OUT_W-1:0]      o_pos_x,
    output logic [spt_pkg::OUT_W-1:0]      o_pos_y,
    output logic [spt_pkg::OUT_W-1:0]      o_pos_z,
    output logic                           o_zero_disparity,
    output logic                           o_saturated
);

    localparam int NUMW = COORD_WIDTH + spt_pkg::BASE_W + FRAC_BITS;

    logic                                              w_en;
    spt_pkg::t_ctrl [NUMW:0]                           w_ctrl;
    logic [NUMW:0][COORD_WIDTH-1:0]                    w_den;
    logic [NUMW:0][spt_pkg::LANES-1:0][NUMW-1:0]       w_num;
    logic [NUMW:0][spt_pkg::LANES-1:0][COORD_WIDTH-1:0] w_rem;
    logic [NUMW:0][spt_pkg::LANES-1:0][NUMW-1:0]       w_quo;

    spt_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .NUMW        (NUMW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_valid && !o_stall),
        .i_left_x    (i_left_x),
        .i_left_y    (i_left_y),
        .i_right_x   (i_right_x),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ctrl      (w_ctrl[0]),
        .o_den       (w_den[0]),
        .o_num       (w_num[0])
    );

    assign w_rem[0] = '0;
    assign w_quo[0] = '0;

    for (genvar g = 0; g < NUMW; g++) begin : g_cell
        spt_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .NUMW        (NUMW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctrl  (w_ctrl[g]),
            .i_den   (w_den[g]),
            .i_num   (w_num[g]),
            .i_rem   (w_rem[g]),
            .i_quo   (w_quo[g]),
            .o_ctrl  (w_ctrl[g+1]),
            .o_den   (w_den[g+1]),
            .o_num   (w_num[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_quo   (w_quo[g+1])
        );
    end

    spt_back #(
        .NUMW (NUMW)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (w_ctrl[NUMW]),
        .i_quo            (w_quo[NUMW]),
        .i_stall          (i_stall),
        .o_en             (w_en),
        .o_valid          (o_valid),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_pos_z          (o_pos_z),
        .o_zero_disparity (o_zero_disparity),
        .o_saturated      (o_saturated)
    );

    assign o_stall = !w_en;

endmodule

### test/tb_top.sv
// Testbench for the stereo point triangulation block: random and directed words checked against a predictor
module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_left_x;
    logic [15:0] i_left_y;
    logic [15:0] i_right_x;
    logic        i_cfg_we;
    logic [spt_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_pos_x;
    logic [31:0] o_pos_y;
    logic [31:0] o_pos_z;
    logic        o_zero_disparity;
    logic        o_saturated;

    typedef struct packed {
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
    } t_point;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        zero;
        logic        sat;
    } t_position;

    t_point    point_q[$];
    t_position position_q[$];
    logic [15:0] cx, cy, foc;
    logic [11:0] base;
    int        errors;
    int        idle_pct;
    int        stall_pct;
    int        hold_off;
    logic      driving;
    logic      in_took;

    stereo_point_triangulation i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] clip_div(input longint num, input longint den,
                                             inout logic sat);
        longint q;
        q = num / den;
        if (q > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (q < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return q[31:0];
    endfunction

    function automatic t_position triangulate(input t_point p);
        t_position r;
        longint d;
        logic sat;
        d = longint'(p.lx) - longint'(p.rx);
        r = '0;
        sat = 1'b0;
        if (d == 0) begin
            r.zero = 1'b1;
        end else begin
            r.px = clip_div((longint'(p.lx) - longint'(cx)) * longint'(base) * 16, d, sat);
            r.py = clip_div((longint'(cy) - longint'(p.ly)) * longint'(base) * 16, d, sat);
            r.pz = clip_div(longint'(foc) * longint'(base) * 16, d, sat);
        end
        r.sat = sat;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task automatic write_reg(input spt_pkg::t_reg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            spt_pkg::REG_PRINCIPAL_X: cx   = val;
            spt_pkg::REG_PRINCIPAL_Y: cy   = val;
            spt_pkg::REG_FOCAL:       foc  = val;
            spt_pkg::REG_BASELINE:    base = val[11:0];
            default: ;
        endcase
    endtask

    task automatic add_point(input logic [15:0] lx, input logic [15:0] ly,
                             input logic [15:0] rx);
        t_point p;
        p.lx = lx;
        p.ly = ly;
        p.rx = rx;
        point_q = {point_q, p};
    endtask

    task automatic drain;
        while (point_q.size() != 0 || driving || position_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            driving = 1'b0;
        end else if (!i_valid || in_took) begin
            if (point_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                t_point p;
                p = point_q.pop_front();
                i_valid   <= 1'b1;
                i_left_x  <= p.lx;
                i_left_y  <= p.ly;
                i_right_x <= p.rx;
                driving = 1'b1;
            end else begin
                i_valid <= 1'b0;
                driving = 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall  <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // accepted input words and results
    always @(posedge i_clk) begin
        in_took = i_rst_n && i_valid && !o_stall;
        if (in_took) begin
            position_q = {position_q, triangulate({i_left_x, i_left_y, i_right_x})};
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (position_q.size() == 0) begin
                report("unexpected word", o_pos_x, 32'h0);
            end else begin
                t_position w;
                w = position_q.pop_front();
                if (o_pos_x != w.px) report("pos_x", o_pos_x, w.px);
                if (o_pos_y != w.py) report("pos_y", o_pos_y, w.py);
                if (o_pos_z != w.pz) report("pos_z", o_pos_z, w.pz);
                if (o_zero_disparity != w.zero) report("zero", o_zero_disparity, w.zero);
                if (o_saturated != w.sat) report("saturated", o_saturated, w.sat);
            end
        end
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [15:0] a;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_left_x = '0;
        i_left_y = '0;
        i_right_x = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = spt_pkg::REG_PRINCIPAL_X;
        i_cfg_data = '0;
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 0;
        driving = 1'b0;
        in_took = 1'b0;
        cx = 16'(spt_pkg::RST_PRINCIPAL_X);
        cy = 16'(spt_pkg::RST_PRINCIPAL_Y);
        foc = 16'(spt_pkg::RST_FOCAL);
        base = 12'(spt_pkg::RST_BASELINE);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words at reset settings
        add_point(16'd6000, 16'd3000, 16'd5000);
        add_point(16'd5000, 16'd3000, 16'd5000);
        add_point(16'd5000, 16'd3000, 16'd6000);
        add_point(16'hffff, 16'hffff, 16'h0000);
        add_point(16'h0000, 16'h0000, 16'hffff);
        add_point(16'h0001, 16'hffff, 16'h0000);
        add_point(16'h0000, 16'h0000, 16'h0001);
        add_point(16'hffff, 16'h0000, 16'hfffe);
        add_point(16'hffff, 16'hffff, 16'hffff);
        add_point(16'h0000, 16'h0000, 16'h0000);
        drain();

        // extreme settings, saturation
        write_reg(spt_pkg::REG_PRINCIPAL_X, 16'h0000);
        write_reg(spt_pkg::REG_PRINCIPAL_Y, 16'hffff);
        write_reg(spt_pkg::REG_FOCAL, 16'hffff);
        write_reg(spt_pkg::REG_BASELINE, 16'hffff);
        add_point(16'hffff, 16'h0000, 16'hfffe);
        add_point(16'h0000, 16'hffff, 16'h0001);
        add_point(16'h8000, 16'h1234, 16'h7fff);
        add_point(16'h0001, 16'h0000, 16'h0000);
        add_point(16'h4000, 16'h4000, 16'h4000);
        drain();
        write_reg(spt_pkg::REG_PRINCIPAL_X, 16'hffff);
        write_reg(spt_pkg::REG_PRINCIPAL_Y, 16'h0000);
        write_reg(spt_pkg::REG_FOCAL, 16'h0000);
        write_reg(spt_pkg::REG_BASELINE, 16'h0000);
        add_point(16'h0000, 16'hffff, 16'h0001);
        add_point(16'hffff, 16'hffff, 16'h0000);
        drain();

        // random phases, settings and pacing vary
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(spt_pkg::REG_PRINCIPAL_X, 16'($urandom));
            write_reg(spt_pkg::REG_PRINCIPAL_Y, 16'($urandom));
            write_reg(spt_pkg::REG_FOCAL, (ph == 2) ? 16'hffff : 16'($urandom));
            write_reg(spt_pkg::REG_BASELINE,
                      (ph == 3) ? 16'h0fff : 16'($urandom_range(4095)));
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            if (ph == 4) hold_off = 300;
            for (int n = 0; n < 165; n++) begin
                a = 16'($urandom);
                case ($urandom_range(3))
                    0: add_point(a, 16'($urandom), a);
                    1: add_point(a, 16'($urandom), a - 16'($urandom_range(1, 3)));
                    2: add_point(a, 16'($urandom), a + 16'($urandom_range(1, 400)));
                    default: add_point(16'($urandom), 16'($urandom), 16'($urandom));
                endcase
            end
            drain();
        end

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
